// ===== hw/rtl/dtq_pkg.sv =====
package dtq_pkg;

    localparam int CAPACITY_DEF = 64;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_TAKE    = 3'd2,
        OP_REWIND  = 3'd3,
        OP_ADVANCE = 3'd4,
        OP_DELETE  = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_WALK_RD,
        S_WALK_CMP,
        S_LINK,
        S_NEXT_RD,
        S_NEXT_USE,
        S_REPORT_RD,
        S_REPORT,
        S_CLEAR,
        S_OUT
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic        capture;     // latch input beat
        logic        alloc;       // pop free list, write new node
        logic        walk_start;  // cur <= head, prv <= null
        logic        walk_rd;     // read node at cur
        logic        walk_step;   // dly -= delta, prv <= cur, cur <= next
        logic        link;        // finish ordered insert
        logic        next_rd;     // read next of the op's node
        logic        next_use;    // apply take/advance/delete update
        logic        rpt_rd;      // read node at cursor for report
        logic        rpt_set;     // build result from node / null
        logic        clear_step;  // rebuild one free-chain entry
        logic        set_status;
        status_t     status;
        logic        out_load;
    } dtq_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        op_t  op;
        logic free_empty;
        logic head_null;
        logic cur_null;    // walk cursor
        logic csr_null;    // list cursor
        logic walk_go;     // cur valid and dly > delta(cur)
        logic clear_done;
        logic out_busy;
    } dtq_sts_t;

endpackage

// ===== hw/rtl/dtq_datapath.sv =====
module dtq_datapath #(
    parameter int CAPACITY = dtq_pkg::CAPACITY_DEF,
    localparam int PW = $clog2(CAPACITY + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dtq_pkg::dtq_cmd_t cmd,
    output dtq_pkg::dtq_sts_t sts,
    input  logic [55:0]       in_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata
);
    import dtq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    logic [15:0]   mem_thread [CAPACITY];
    logic [31:0]   mem_delta  [CAPACITY];
    logic [PW-1:0] mem_next   [CAPACITY];

    op_t           op_reg;
    logic [15:0]   tid_reg;
    logic [31:0]   dly_reg, dly_next;
    logic [PW-1:0] head_reg, tail_reg, csr_reg, prev_reg, free_reg;
    logic [PW-1:0] cur_reg, prv_reg, n_reg;
    logic [PW-1:0] clr_reg;
    logic [15:0]   rd_thread_reg;
    logic [31:0]   rd_delta_reg;
    logic [PW-1:0] rd_next_reg;
    logic [PW-1:0] free_nx_reg;
    logic [1:0]    res_st_reg;
    logic [15:0]   res_tid_reg;
    logic [31:0]   res_dly_reg;
    logic          ov_reg;
    logic [55:0]   od_reg;

    // shared read port for node reads by walk, next and report (the free-head successor has its own read)
    logic [PW-1:0] rd_addr;
    logic          rd_en;
    // write-port controls: node write, next-field write and delta-field write
    logic          wr_next_en, wr_node_en, wr_delta_en;
    logic [PW-1:0] wr_next_addr, wr_next_data;
    logic [PW-1:0] wr_delta_addr;
    logic [31:0]   wr_delta_data;

    function automatic logic is_node(input logic [PW-1:0] p);
        return p < NIL;
    endfunction

    always_comb begin
        rd_en   = cmd.walk_rd || cmd.next_rd || cmd.rpt_rd;
        rd_addr = free_reg;
        if (cmd.walk_rd) begin
            rd_addr = cur_reg;
        end else if (cmd.next_rd) begin
            rd_addr = (op_reg == OP_TAKE) ? head_reg : csr_reg;
        end else if (cmd.rpt_rd) begin
            rd_addr = csr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en && is_node(rd_addr)) begin
            rd_thread_reg <= mem_thread[rd_addr[AW-1:0]];
            rd_delta_reg  <= mem_delta[rd_addr[AW-1:0]];
            rd_next_reg   <= mem_next[rd_addr[AW-1:0]];
        end
    end

    // successor of the free head, kept fresh for the next pop
    always_ff @(posedge aclk) begin
        if (is_node(free_reg)) begin
            free_nx_reg <= mem_next[free_reg[AW-1:0]];
        end
    end

    // write-port selection
    always_comb begin
        wr_node_en    = cmd.alloc;
        wr_next_en    = 1'b0;
        wr_next_addr  = n_reg;
        wr_next_data  = NIL;
        wr_delta_en   = 1'b0;
        wr_delta_addr = cur_reg;
        wr_delta_data = rd_delta_reg - dly_reg;
        if (cmd.clear_step) begin
            wr_next_en   = 1'b1;
            wr_next_addr = clr_reg;
            wr_next_data = clr_reg + PW'(1);
        end else if (cmd.link) begin
            if (is_node(cur_reg)) begin
                wr_delta_en = 1'b1;
                if (is_node(prv_reg)) begin
                    wr_next_en   = 1'b1;
                    wr_next_addr = prv_reg;
                    wr_next_data = n_reg;
                end
            end else if (is_node(tail_reg)) begin
                wr_next_en   = 1'b1;
                wr_next_addr = tail_reg;
                wr_next_data = n_reg;
            end
        end else if (cmd.next_use) begin
            if (op_reg == OP_TAKE) begin
                wr_next_en   = 1'b1;
                wr_next_addr = head_reg;
                wr_next_data = free_reg;
            end else if (op_reg == OP_DELETE) begin
                // first free the node, prev relink done by second write below
                wr_next_en   = 1'b1;
                wr_next_addr = csr_reg;
                wr_next_data = free_reg;
            end
        end else if (cmd.alloc && op_reg == OP_APPEND && !sts.head_null
                     && is_node(tail_reg)) begin
            wr_next_en   = 1'b1;
            wr_next_addr = tail_reg;
            wr_next_data = free_reg;
        end
    end

    // delete also relinks prev: second next-port on a separate cycle (rpt_rd)
    logic          del_link_en;
    logic [PW-1:0] del_link_addr, del_link_data;
    logic          del_pend_reg;

    always_comb begin
        // a prev equal to the freed node keeps its free-chain link
        del_link_en   = cmd.rpt_rd && del_pend_reg && is_node(prev_reg)
                        && (prev_reg != free_reg);
        del_link_addr = prev_reg;
        del_link_data = csr_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_node_en && is_node(free_reg)) begin
            mem_thread[free_reg[AW-1:0]] <= tid_reg;
            mem_delta[free_reg[AW-1:0]]  <= dly_reg;
            mem_next[free_reg[AW-1:0]]   <= NIL;
        end
        if (cmd.link && is_node(n_reg)) begin
            mem_delta[n_reg[AW-1:0]] <= dly_reg;
            mem_next[n_reg[AW-1:0]]  <= is_node(cur_reg) ? cur_reg : NIL;
        end
        if (wr_delta_en && is_node(wr_delta_addr)) begin
            mem_delta[wr_delta_addr[AW-1:0]] <= wr_delta_data;
        end
        if (wr_next_en && is_node(wr_next_addr)) begin
            mem_next[wr_next_addr[AW-1:0]] <= wr_next_data;
        end else if (del_link_en) begin
            mem_next[del_link_addr[AW-1:0]] <= del_link_data;
        end
    end

    assign dly_next = dly_reg - rd_delta_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= op_t'(in_data[2:0]);
            tid_reg <= in_data[18:3];
            dly_reg <= in_data[50:19];
        end else if (cmd.walk_step) begin
            dly_reg <= dly_next;
        end
        if (cmd.alloc) begin
            n_reg <= free_reg;
        end
        if (cmd.walk_start) begin
            cur_reg <= head_reg;
            prv_reg <= NIL;
        end else if (cmd.walk_step) begin
            prv_reg <= cur_reg;
            cur_reg <= rd_next_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= NIL;
            tail_reg     <= NIL;
            csr_reg      <= NIL;
            prev_reg     <= NIL;
            free_reg     <= '0;
            clr_reg      <= '0;
            del_pend_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                clr_reg      <= '0;
                del_pend_reg <= 1'b0;
            end
            if (cmd.clear_step) begin
                clr_reg  <= clr_reg + PW'(1);
                head_reg <= NIL;
                tail_reg <= NIL;
                csr_reg  <= NIL;
                prev_reg <= NIL;
                free_reg <= '0;
            end
            if (cmd.alloc) begin
                free_reg <= free_nx_reg;
                if (sts.head_null) begin
                    head_reg <= free_reg;
                    tail_reg <= free_reg;
                end else if (op_reg == OP_APPEND) begin
                    tail_reg <= free_reg;
                end
            end
            if (cmd.link) begin
                if (is_node(cur_reg)) begin
                    if (!is_node(prv_reg)) head_reg <= n_reg;
                end else begin
                    tail_reg <= n_reg;
                end
                csr_reg  <= cur_reg;
                prev_reg <= n_reg;
            end
            if (cmd.walk_start && op_reg == OP_REWIND) begin
                csr_reg  <= head_reg;
                prev_reg <= NIL;
            end
            if (cmd.next_use) begin
                unique case (op_reg)
                    OP_TAKE: begin
                        if (csr_reg == head_reg) csr_reg <= rd_next_reg;
                        if (prev_reg == head_reg) prev_reg <= NIL;
                        head_reg <= rd_next_reg;
                        if (!is_node(rd_next_reg)) tail_reg <= NIL;
                        free_reg <= head_reg;
                    end
                    OP_ADVANCE: begin
                        prev_reg <= csr_reg;
                        csr_reg  <= rd_next_reg;
                    end
                    OP_DELETE: begin
                        free_reg <= csr_reg;
                        csr_reg  <= rd_next_reg;
                        if (csr_reg == head_reg) begin
                            head_reg <= rd_next_reg;
                            if (csr_reg == tail_reg) tail_reg <= NIL;
                        end else begin
                            if (csr_reg == tail_reg) tail_reg <= prev_reg;
                            del_pend_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (cmd.set_status) begin
            res_st_reg  <= cmd.status;
            res_tid_reg <= '0;
            res_dly_reg <= '0;
        end else if (cmd.next_use && op_reg == OP_TAKE) begin
            res_st_reg  <= ST_OK;
            res_tid_reg <= rd_thread_reg;
            res_dly_reg <= rd_delta_reg;
        end else if (cmd.rpt_set) begin
            if (is_node(csr_reg)) begin
                res_st_reg  <= ST_OK;
                res_tid_reg <= rd_thread_reg;
                res_dly_reg <= rd_delta_reg;
            end else begin
                res_st_reg  <= ST_EMPTY;
                res_tid_reg <= '0;
                res_dly_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            od_reg <= {6'd0, res_dly_reg, res_tid_reg, res_st_reg};
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    always_comb begin
        sts.op         = op_reg;
        sts.free_empty = !is_node(free_reg);
        sts.head_null  = !is_node(head_reg);
        sts.cur_null   = !is_node(cur_reg);
        sts.csr_null   = !is_node(csr_reg);
        sts.walk_go    = is_node(cur_reg) && (dly_reg > rd_delta_reg);
        sts.clear_done = (clr_reg == NIL);
        sts.out_busy   = ov_reg && !m_tready;
    end

endmodule

// ===== hw/rtl/dtq_ctrl.sv =====
module dtq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dtq_pkg::dtq_sts_t sts,
    output dtq_pkg::dtq_cmd_t cmd
);
    import dtq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: if (sts.clear_done) state_next = S_IDLE;
            S_IDLE: if (s_tvalid) state_next = S_DISPATCH;
            S_DISPATCH: begin
                unique case (sts.op)
                    OP_APPEND, OP_INSERT: begin
                        if (sts.free_empty) state_next = S_OUT;
                        else if (sts.op == OP_INSERT && !sts.head_null)
                            state_next = S_WALK_RD;
                        else state_next = S_ALLOC;
                    end
                    OP_TAKE: state_next = sts.head_null ? S_OUT : S_NEXT_RD;
                    OP_REWIND: state_next = S_REPORT_RD;
                    OP_ADVANCE, OP_DELETE:
                        state_next = sts.csr_null ? S_OUT : S_NEXT_RD;
                    OP_CLEAR: state_next = S_CLEAR;
                    default: state_next = S_OUT;
                endcase
            end
            S_ALLOC: state_next = (sts.op == OP_INSERT && !sts.head_null) ?
                                  S_LINK : S_OUT;
            S_WALK_RD: state_next = S_WALK_CMP;
            S_WALK_CMP: state_next = sts.walk_go ? S_WALK_RD : S_ALLOC;
            S_LINK: state_next = S_OUT;
            S_NEXT_RD: state_next = S_NEXT_USE;
            S_NEXT_USE: state_next = (sts.op == OP_TAKE) ? S_OUT : S_REPORT_RD;
            S_REPORT_RD: state_next = S_REPORT;
            S_REPORT: state_next = S_OUT;
            S_CLEAR: if (sts.clear_done) state_next = S_OUT;
            S_OUT: if (!sts.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.status = ST_OK;
        s_tready   = (state_reg == S_IDLE);
        unique case (state_reg)
            // free chain built once after reset, no result beat
            S_INIT: cmd.clear_step = !sts.clear_done;
            S_IDLE: cmd.capture = s_tvalid;
            S_DISPATCH: begin
                cmd.set_status = 1'b1;
                if ((sts.op == OP_APPEND || sts.op == OP_INSERT) && sts.free_empty)
                    cmd.status = ST_FULL;
                else if (sts.op == OP_TAKE && sts.head_null)
                    cmd.status = ST_EMPTY;
                else if ((sts.op == OP_ADVANCE || sts.op == OP_DELETE)
                         && sts.csr_null)
                    cmd.status = ST_EMPTY;
                cmd.walk_start = 1'b1;
            end
            S_ALLOC:     cmd.alloc = 1'b1;
            S_WALK_RD:   cmd.walk_rd = 1'b1;
            S_WALK_CMP:  cmd.walk_step = sts.walk_go;
            S_LINK:      cmd.link = 1'b1;
            S_NEXT_RD:   cmd.next_rd = 1'b1;
            S_NEXT_USE:  cmd.next_use = 1'b1;
            S_REPORT_RD: cmd.rpt_rd = 1'b1;
            S_REPORT:    cmd.rpt_set = 1'b1;
            S_CLEAR:     cmd.clear_step = !sts.clear_done;
            S_OUT:       cmd.out_load = !sts.out_busy;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/delta_timer_queue.sv =====
// Ordered insert walks the list from the head, reading and comparing each node passed,
// until the delay no longer exceeds that node's delta. Clear rebuilds the free chain.
// One beat in flight; next beat accepted in the cycle after the result is registered.
// Reset (aresetn low, synchronous): empty list; then the free chain is built from
// node 0 with s_tready low.
module delta_timer_queue #(
    parameter int CAPACITY = dtq_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // opcode[2:0], thread_id[18:3], delay[50:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[1:0], out_thread_id[17:2], out_delta[49:18]
);
    import dtq_pkg::*;

    dtq_cmd_t cmd;
    dtq_sts_t sts;

    dtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dtq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int CAP = 64;
    localparam int NIL = CAP;

    typedef struct packed {
        logic [31:0] delta;
        logic [15:0] tid;
        status_t     status;
    } qres_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    delta_timer_queue #(.CAPACITY(CAP)) i_dut (.*);

    initial forever #5 aclk = ~aclk;

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    // shadow copy of the node store
    logic [15:0] nthr [CAP];
    logic [31:0] ndel [CAP];
    int          nnext [CAP];
    int          head, tail, csr, prv, fhead, nlinked;
    qres_t       pending [$];
    int          errors = 0;
    bit          calm = 1'b0;

    function automatic void chain_init();
        for (int i = 0; i < CAP; i++) nnext[i] = i + 1;
        fhead = 0; head = NIL; tail = NIL; csr = NIL; prv = NIL; nlinked = 0;
    endfunction

    function automatic qres_t at_node(int p);
        qres_t r;
        r = '0;
        if (p < CAP) begin
            r.tid = nthr[p]; r.delta = ndel[p];
        end else begin
            r.status = ST_EMPTY;
        end
        return r;
    endfunction

    function automatic void release_node(int n);
        nnext[n] = fhead; fhead = n; nlinked--;
    endfunction

    function automatic qres_t queue_op(op_t op, logic [15:0] tid, logic [31:0] dly);
        qres_t r;
        int n, c, p, nx;
        r = '0;
        case (op)
            OP_APPEND, OP_INSERT: begin
                if (fhead >= CAP) begin
                    r.status = ST_FULL;
                    return r;
                end
                n = fhead; fhead = nnext[n]; nlinked++;
                nthr[n] = tid; nnext[n] = NIL;
                if (head >= CAP) begin
                    ndel[n] = dly; head = n; tail = n;
                end else if (op == OP_APPEND) begin
                    ndel[n] = dly; nnext[tail] = n; tail = n;
                end else begin
                    p = NIL; c = head;
                    while (c < CAP && dly > ndel[c]) begin
                        dly -= ndel[c]; p = c; c = nnext[c];
                    end
                    ndel[n] = dly;
                    if (c < CAP) begin
                        ndel[c] -= dly; nnext[n] = c;
                        if (p < CAP) nnext[p] = n; else head = n;
                    end else begin
                        nnext[tail] = n; tail = n;
                    end
                    csr = c; prv = n;
                end
            end
            OP_TAKE: begin
                n = head;
                if (n >= CAP) return at_node(NIL);
                r = at_node(n);
                nx = nnext[n];
                if (csr == n) csr = nx;
                if (prv == n) prv = NIL;
                head = nx;
                if (head >= CAP) tail = NIL;
                release_node(n);
            end
            OP_REWIND: begin
                csr = head; prv = NIL;
                r = at_node(csr);
            end
            OP_ADVANCE: begin
                if (csr >= CAP) return at_node(NIL);
                prv = csr; csr = nnext[csr];
                r = at_node(csr);
            end
            OP_DELETE: begin
                n = csr;
                if (n >= CAP) return at_node(NIL);
                nx = nnext[n];
                if (n == head) begin
                    head = nx;
                    if (n == tail) tail = NIL;
                    csr = head;
                end else begin
                    if (n == tail) tail = prv;
                    if (prv < CAP) nnext[prv] = nx;
                    csr = nx;
                end
                release_node(n);
                r = at_node(csr);
            end
            OP_CLEAR: chain_init();
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_cmd(op_t op, logic [15:0] tid, logic [31:0] dly);
        if (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (!calm && $urandom_range(99) < 10);
        end
        pending.push_back(queue_op(op, tid, dly));
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, dly, tid, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                qres_t got, want;
                got = qres_t'(m_tdata[49:0]);
                if (pending.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    errors++;
                end else begin
                    want = pending.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        errors++;
                    end
                    if (got.tid !== want.tid) begin
                        $display("%0t: thread exp %h got %h", $time, want.tid, got.tid);
                        errors++;
                    end
                    if (got.delta !== want.delta) begin
                        $display("%0t: delta exp %h got %h", $time, want.delta, got.delta);
                        errors++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 10);
        end
    end

    function automatic logic [31:0] rnd_delay();
        case ($urandom_range(3))
            0: return $urandom_range(20);
            1: return $urandom_range(1000);
            2: return $urandom;
            default: return 32'hFFFF_FFF0 + $urandom_range(15);
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(OP_TAKE, 16'h0, 32'h0);
        send_cmd(OP_REWIND, 16'h0, 32'h0);
        send_cmd(OP_ADVANCE, 16'h0, 32'h0);
        send_cmd(OP_DELETE, 16'h0, 32'h0);
        send_cmd(OP_INSERT, 16'hFFFF, 32'd100);
        send_cmd(OP_INSERT, 16'h0001, 32'd40);
        send_cmd(OP_INSERT, 16'h0002, 32'd100);
        send_cmd(OP_INSERT, 16'h0003, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 16'h0004, 32'd0);
        send_cmd(OP_APPEND, 16'hA5A5, 32'h5A5A_5A5A);
        send_cmd(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(OP_REWIND, 16'h0, 32'h0);
        send_cmd(OP_ADVANCE, 16'h0, 32'h0);
        send_cmd(OP_DELETE, 16'h0, 32'h0);
        send_cmd(OP_TAKE, 16'h0, 32'h0);
        send_cmd(OP_CLEAR, 16'h0, 32'h0);
        send_cmd(OP_TAKE, 16'h0, 32'h0);
    endtask

    // fills the store to hit the full status on both insert kinds
    task automatic test_full();
        for (int i = 0; i < CAP; i++)
            send_cmd(i[0] ? OP_INSERT : OP_APPEND, 16'(i), 32'($urandom_range(50)));
        send_cmd(OP_APPEND, 16'h1234, 32'd1);
        send_cmd(OP_INSERT, 16'h4321, 32'd1);
        send_cmd(OP_REWIND, 16'h0, 32'h0);
        for (int i = 0; i < 6; i++) send_cmd(OP_ADVANCE, 16'h0, 32'h0);
        send_cmd(OP_DELETE, 16'h0, 32'h0);
        send_cmd(OP_CLEAR, 16'h0, 32'h0);
    endtask

    task automatic test_random(int count);
        op_t op;
        int  pick;
        for (int i = 0; i < count; i++) begin
            calm = (i >= 300 && i < 450);
            pick = $urandom_range(99);
            if (pick < 30) op = OP_INSERT;
            else if (pick < 42) op = OP_APPEND;
            else if (pick < 57) op = OP_TAKE;
            else if (pick < 67) op = OP_REWIND;
            else if (pick < 82) op = OP_ADVANCE;
            else if (pick < 95) op = OP_DELETE;
            else if (pick < 97) op = OP_CLEAR;
            else op = OP_NONE;
            // keep most lists short so inserts stay fast
            if (nlinked > 12 && (op == OP_INSERT || op == OP_APPEND) && $urandom_range(3) != 0)
                op = OP_TAKE;
            send_cmd(op, 16'($urandom), rnd_delay());
        end
        calm = 1'b0;
    endtask

    initial begin
        int guard;
        chain_init();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full();
        test_random(850);
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (2 * CAP + 20) @(posedge aclk);
        if (errors == 0 && pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_datapath.sv
hw/rtl/dtq_ctrl.sv
hw/rtl/delta_timer_queue.sv
dv/tb.sv
